// ===== rtl/wsu_pkg.sv =====
// Shared types and constants for the wheel suspension update block.
// Used by wsu_calc, wheel_suspension_update_top and the testbench; no dependencies.
`default_nettype none

package wsu_pkg;

	localparam int WheelsDefault = 4;

	// one full tick in fraction units, and the rounding half for the >>16
	localparam logic [16:0] FracOne  = 17'h10000;
	localparam logic [15:0] FracHalf = 16'h8000;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_LOAD   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_TARGET_DECAY   = 3'd0,
		REG_RETURN_STEP    = 3'd1,
		REG_CONTACT_LIMIT  = 3'd2,
		REG_TRAVEL_LIMIT   = 3'd3,
		REG_SOFT_THRESHOLD = 3'd4
	} reg_idx_t;

	localparam logic [7:0]         RstTargetDecay   = 8'd4;
	localparam logic [9:0]         RstReturnStep    = 10'd128;
	localparam logic [14:0]        RstContactLimit  = 15'd192;
	localparam logic [14:0]        RstTravelLimit   = 15'd384;
	localparam logic signed [15:0] RstSoftThreshold = -16'sd288;

	typedef struct packed {
		logic [7:0]         base_target_decay;
		logic [9:0]         base_return_step;
		logic [14:0]        pos_contact_max;
		logic [14:0]        travel_limit;
		logic signed [15:0] soft_contact_threshold;
	} cfg_t;

	// one input word after the first stage: rates already scaled by the fraction
	typedef struct packed {
		op_t                op;
		logic [1:0]         wheel;
		logic               frac_zero;
		logic [7:0]         decay;
		logic [9:0]         step;
		logic signed [15:0] contact;
		logic signed [15:0] target_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] settled;
		logic signed [15:0] defl_next;
		logic signed [15:0] tgt_next;
		logic               cleared;
	} calc_res_t;

endpackage

`default_nettype wire

// ===== rtl/wsu_calc.sv =====
// Combinational wheel update: target decay and deflection response for one word.
// Depends on wsu_pkg for the config, item and result structs.
`default_nettype none

module wsu_calc import wsu_pkg::*; (
	input  cfg_t               cfg,
	input  item_t              item,
	input  logic signed [15:0] prev,
	input  logic signed [15:0] tgt,
	output calc_res_t          res
);

	logic signed [15:0] decay_s;
	logic signed [15:0] step_s;
	logic signed [15:0] limit_s;
	logic signed [15:0] travel_s;
	logic signed [15:0] ntravel_s;
	logic signed [15:0] tgt_dec;
	logic signed [15:0] neg_c;
	logic signed [15:0] c;
	logic signed [15:0] d;
	logic signed [15:0] adj;
	logic signed [15:0] sum;
	logic signed [15:0] c3;
	logic signed [15:0] scaled;
	logic               cleared;

	assign decay_s   = $signed({8'b0, item.decay});
	assign step_s    = $signed({6'b0, item.step});
	assign limit_s   = $signed({1'b0, cfg.pos_contact_max});
	assign travel_s  = $signed({1'b0, cfg.travel_limit});
	assign ntravel_s = 16'sd0 - travel_s;
	assign neg_c     = 16'sd0 - item.contact;
	assign sum       = item.contact + prev;
	assign c3        = item.contact + (item.contact <<< 1);
	assign scaled    = c3 >>> 2;

	// decay target toward zero, never past it
	always_comb begin
		tgt_dec = tgt;
		if (tgt < 16'sd0) begin
			tgt_dec = tgt + decay_s;
			if (tgt_dec > 16'sd0)
				tgt_dec = 16'sd0;
		end else if (tgt > 16'sd0) begin
			tgt_dec = tgt - decay_s;
			if (tgt_dec < 16'sd0)
				tgt_dec = 16'sd0;
		end
	end

	always_comb begin
		c       = item.contact;
		d       = prev;
		adj     = 16'sd0;
		cleared = 1'b0;
		// negative contact smaller than the deflection counts as none
		if (item.contact < 16'sd0 && prev > neg_c)
			c = 16'sd0;
		if (c == 16'sd0) begin
			if (prev > tgt_dec) begin
				d = prev - step_s;
				if (d < tgt_dec)
					d = tgt_dec;
				adj = prev - d;
			end else if (prev < tgt_dec) begin
				d = prev + step_s;
				if (d > tgt_dec)
					d = tgt_dec;
			end
		end else if (c > 16'sd0) begin
			if (c > limit_s)
				c = limit_s;
			d = prev + c;
			if (d > travel_s)
				d = travel_s;
			cleared = 1'b1;
		end else begin
			if (sum > cfg.soft_contact_threshold) begin
				d = sum;
			end else begin
				// hard contact: three quarters, floored at the negative travel limit
				d = prev + scaled;
				if (d < ntravel_s)
					d = ntravel_s;
			end
			adj = prev - d + c;
		end
	end

	always_comb begin
		if (item.op == OP_LOAD) begin
			res.settled   = prev;
			res.defl_next = prev;
			res.tgt_next  = item.target_value;
			res.cleared   = 1'b0;
		end else if (item.frac_zero) begin
			res.settled   = prev;
			res.defl_next = prev;
			res.tgt_next  = tgt;
			res.cleared   = 1'b0;
		end else begin
			res.settled   = prev + adj;
			res.defl_next = d;
			res.tgt_next  = tgt_dec;
			res.cleared   = cleared;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wheel_suspension_update_top.sv =====
// Two register stages. Throughput: one word per cycle while the receiver does not hold out_ready low.
// Stage 1 registers the word with the fraction-scaled decay and return step; stage 2
// reads the wheel state, updates it and registers the result at the same edge, so a
// following word for the same wheel sees the new state directly.
// Reset clears all wheel targets and deflections and loads the register defaults.
// Depends on wsu_pkg and wsu_calc.
`default_nettype none

module wheel_suspension_update_top import wsu_pkg::*; #(
	parameter int WHEELS = WheelsDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [1:0]         wheel,
	input  wire logic signed [15:0] ground_delta,
	input  wire logic [16:0]        step_fraction,
	input  wire logic signed [15:0] target_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      settled_value,
	output logic signed [15:0]      deflection_now,
	output logic                    contact_cleared
);

	localparam int IdxW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

	cfg_t               cfg_q;
	item_t              item_s1;
	logic               valid_s1;
	logic               advance;
	logic [16:0]        frac_sat;
	logic [24:0]        decay_prod;
	logic [26:0]        step_prod;
	logic [IdxW+1:0]    wheel_ext;
	logic [IdxW-1:0]    idx;
	logic               in_range;
	logic signed [15:0] tgt_q [WHEELS];
	logic signed [15:0] defl_q [WHEELS];
	logic signed [15:0] prev;
	logic signed [15:0] tgt;
	calc_res_t          res;
	logic               out_valid_q;
	logic signed [15:0] settled_q;
	logic signed [15:0] defl_out_q;
	logic               cleared_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_target_decay      <= RstTargetDecay;
			cfg_q.base_return_step       <= RstReturnStep;
			cfg_q.pos_contact_max        <= RstContactLimit;
			cfg_q.travel_limit           <= RstTravelLimit;
			cfg_q.soft_contact_threshold <= RstSoftThreshold;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET_DECAY:   cfg_q.base_target_decay      <= cfg_data[7:0];
				REG_RETURN_STEP:    cfg_q.base_return_step       <= cfg_data[9:0];
				REG_CONTACT_LIMIT:  cfg_q.pos_contact_max        <= cfg_data[14:0];
				REG_TRAVEL_LIMIT:   cfg_q.travel_limit           <= cfg_data[14:0];
				REG_SOFT_THRESHOLD: cfg_q.soft_contact_threshold <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 1: scale the rates by the saturated fraction, with rounding
	assign frac_sat   = (step_fraction > FracOne) ? FracOne : step_fraction;
	assign decay_prod = 25'(cfg_q.base_target_decay) * 25'(frac_sat) + 25'(FracHalf);
	assign step_prod  = 27'(cfg_q.base_return_step) * 27'(frac_sat) + 27'(FracHalf);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op           <= op_t'(operation);
			item_s1.wheel        <= wheel;
			item_s1.frac_zero    <= (step_fraction == 17'd0);
			item_s1.decay        <= decay_prod[23:16];
			item_s1.step         <= step_prod[25:16];
			item_s1.contact      <= ground_delta;
			item_s1.target_value <= target_value;
		end
	end

	// stage 2: wheel state lookup and update
	assign wheel_ext = (IdxW + 2)'(item_s1.wheel);
	assign idx       = wheel_ext[IdxW-1:0];
	assign in_range  = (32'(item_s1.wheel) < 32'(WHEELS));
	assign prev      = in_range ? defl_q[idx] : 16'sd0;
	assign tgt       = in_range ? tgt_q[idx] : 16'sd0;

	wsu_calc u_calc (
		.cfg  (cfg_q),
		.item (item_s1),
		.prev (prev),
		.tgt  (tgt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEELS; i++) begin
				tgt_q[i]  <= 16'sd0;
				defl_q[i] <= 16'sd0;
			end
		end else if (advance && in_range) begin
			tgt_q[idx]  <= res.tgt_next;
			defl_q[idx] <= res.defl_next;
		end
	end

	// result register; hold while downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_range) begin
				settled_q  <= res.settled;
				defl_out_q <= res.defl_next;
				cleared_q  <= res.cleared;
			end else begin
				// drop words for absent wheels with an all-zero result
				settled_q  <= 16'sd0;
				defl_out_q <= 16'sd0;
				cleared_q  <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign settled_value   = settled_q;
	assign deflection_now  = defl_out_q;
	assign contact_cleared = cleared_q;

	// positive contact never leaves the deflection above the travel cap
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && res.cleared
			|-> res.defl_next <= $signed({1'b0, cfg_q.travel_limit}))
		else $error("deflection above travel limit after positive contact");

	// target decay never crosses zero from above
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && item_s1.op == OP_UPDATE && tgt >= 16'sd0
			|-> res.tgt_next >= 16'sd0)
		else $error("target decay crossed zero from above");

	// a word for an absent wheel yields an all-zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && !in_range
			|=> out_valid_q && settled_q == 16'sd0 && defl_out_q == 16'sd0 && !cleared_q)
		else $error("absent wheel produced a nonzero result");

	// load and zero-fraction words leave the deflection unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && (item_s1.op == OP_LOAD || item_s1.frac_zero)
			|=> defl_q[$past(idx)] == $past(prev) && defl_out_q == settled_q)
		else $error("load or zero-fraction word changed the deflection");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for wheel_suspension_update_top: directed and random words checked against a
// per-wheel suspension predictor held in a small scoreboard class.
// Depends on wsu_pkg and the wheel_suspension_update_top RTL.
`timescale 1ns / 1ps

import wsu_pkg::*;

typedef struct packed {
	logic signed [15:0] settled;
	logic signed [15:0] defl;
	logic               cleared;
} settle_t;

class suspension_scoreboard;
	logic signed [15:0] tgt_st[WheelsDefault];
	logic signed [15:0] defl_st[WheelsDefault];
	logic [7:0]         decay_base;
	logic [9:0]         return_base;
	logic [14:0]        contact_cap;
	logic [14:0]        travel_cap;
	logic signed [15:0] soft_thr;
	settle_t            settle_q[$];
	int                 errors;

	function new();
		for (int i = 0; i < WheelsDefault; i++) begin
			tgt_st[i]  = '0;
			defl_st[i] = '0;
		end
		decay_base  = RstTargetDecay;
		return_base = RstReturnStep;
		contact_cap = RstContactLimit;
		travel_cap  = RstTravelLimit;
		soft_thr    = RstSoftThreshold;
		errors      = 0;
	endfunction

	function int pending();
		return settle_q.size();
	endfunction

	function int w16(int v);
		logic signed [15:0] s;
		s = v[15:0];
		return int'(s);
	endfunction

	function void set_reg(reg_idx_t idx, logic [15:0] data);
		case (idx)
			REG_TARGET_DECAY:   decay_base  = data[7:0];
			REG_RETURN_STEP:    return_base = data[9:0];
			REG_CONTACT_LIMIT:  contact_cap = data[14:0];
			REG_TRAVEL_LIMIT:   travel_cap  = data[14:0];
			REG_SOFT_THRESHOLD: soft_thr    = data;
			default: ;
		endcase
	endfunction

	// predict the result of one accepted word and update the wheel state
	function void note_word(op_t op, logic [1:0] w, logic signed [15:0] contact,
			logic [16:0] frac, logic signed [15:0] tval);
		int          p, d, t, c, adj, dec, stp, sc;
		int unsigned f, db, rb;
		settle_t     r;
		p = int'(defl_st[w]);
		if (op == OP_LOAD || frac == '0) begin
			if (op == OP_LOAD)
				tgt_st[w] = tval;
			r.settled = p[15:0];
			r.defl    = p[15:0];
			r.cleared = 1'b0;
			settle_q.push_back(r);
			return;
		end
		f   = 32'((frac > FracOne) ? FracOne : frac);
		db  = 32'(decay_base);
		rb  = 32'(return_base);
		dec = int'((db * f + FracHalf) >> 16);
		stp = int'((rb * f + FracHalf) >> 16);

		// decay the target toward zero, never past it
		t = int'(tgt_st[w]);
		if (t < 0) begin
			t = w16(t + dec);
			if (t > 0) t = 0;
		end else if (t > 0) begin
			t = w16(t - dec);
			if (t < 0) t = 0;
		end
		tgt_st[w] = t[15:0];

		d   = p;
		adj = 0;
		r.cleared = 1'b0;
		c = int'(contact);
		if (c < 0 && d > w16(-c))
			c = 0;

		if (c == 0) begin
			if (d > t) begin
				d = w16(d - stp);
				if (d < t) d = t;
				adj = w16(p - d);
			end else if (d < t) begin
				d = w16(d + stp);
				if (d > t) d = t;
			end
		end else if (c > 0) begin
			if (c > int'(contact_cap)) c = int'(contact_cap);
			d = w16(d + c);
			if (d > int'(travel_cap)) d = int'(travel_cap);
			r.cleared = 1'b1;
		end else begin
			if (w16(c + d) > int'(soft_thr)) begin
				d = w16(d + c);
			end else begin
				// hard contact: three quarters, floored, then limit the travel
				sc = w16(c * 3) >>> 2;
				d  = w16(d + sc);
				if (d < -int'(travel_cap)) d = -int'(travel_cap);
			end
			adj = w16(w16(p - d) + c);
		end
		defl_st[w] = d[15:0];
		r.settled  = 16'(w16(p + adj));
		r.defl     = d[15:0];
		settle_q.push_back(r);
	endfunction

	function void check_result(logic signed [15:0] settled, logic signed [15:0] defl,
			logic cleared);
		settle_t e;
		if (settle_q.size() == 0) begin
			$error("result word with nothing pending: settled_value %0d", settled);
			errors++;
			return;
		end
		e = settle_q.pop_front();
		if (settled !== e.settled) begin
			$error("settled_value expected %0d actual %0d", e.settled, settled);
			errors++;
		end
		if (defl !== e.defl) begin
			$error("deflection_now expected %0d actual %0d", e.defl, defl);
			errors++;
		end
		if (cleared !== e.cleared) begin
			$error("contact_cleared expected %0d actual %0d", e.cleared, cleared);
			errors++;
		end
	endfunction
endclass

module tb;
	localparam int          PhaseCount  = 6;
	localparam int          PhaseItems  = 265;
	localparam int          LongHold    = 60;
	localparam int          DrainSlack  = 4;
	localparam int unsigned CycleLimit  = 200000;
	localparam logic [2:0]  RegSpare    = 3'd7;

	logic               clk;
	logic               arst_n          = 1'b0;
	logic               cfg_we          = 1'b0;
	logic [2:0]         cfg_index       = '0;
	logic [15:0]        cfg_data        = '0;
	logic               in_valid        = 1'b0;
	logic               in_ready;
	op_t                operation       = OP_UPDATE;
	logic [1:0]         wheel           = '0;
	logic signed [15:0] ground_delta    = '0;
	logic [16:0]        step_fraction   = '0;
	logic signed [15:0] target_value    = '0;
	logic               out_valid;
	logic               out_ready       = 1'b0;
	logic signed [15:0] settled_value;
	logic signed [15:0] deflection_now;
	logic               contact_cleared;

	bit                   calm     = 1'b0;
	bit                   hold_req = 1'b0;
	int unsigned          cycle_count = 0;
	suspension_scoreboard sb;

	wheel_suspension_update_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.wheel           (wheel),
		.ground_delta    (ground_delta),
		.step_fraction   (step_fraction),
		.target_value    (target_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.settled_value   (settled_value),
		.deflection_now  (deflection_now),
		.contact_cleared (contact_cleared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("wheel_suspension_update_top verification failed");
		$finish;
	end

	// note accepted words and check results on the pre-edge values
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_word(operation, wheel, ground_delta, step_fraction, target_value);
		if (arst_n && out_valid && out_ready)
			sb.check_result(settled_value, deflection_now, contact_cleared);
	end

	// receiver: short random stalls, one long hold on request
	initial begin
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// hold the word until accepted; valid stays high for a following word
	task automatic send_word(input op_t op, input logic [1:0] w, input logic signed [15:0] c,
			input logic [16:0] f, input logic signed [15:0] tv);
		in_valid      <= 1'b1;
		operation     <= op;
		wheel         <= w;
		ground_delta  <= c;
		step_fraction <= f;
		target_value  <= tv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DrainSlack) @(posedge clk);
	endtask

	// upper bits beyond each register's width carry junk that must be dropped
	task automatic program_regs(input logic [7:0] decay, input logic [9:0] ret,
			input logic [14:0] cmax, input logic [14:0] tmax, input logic signed [15:0] thr);
		logic [15:0] junk;
		logic [15:0] vals[5];
		junk    = 16'($urandom);
		vals[0] = {junk[15:8], decay};
		vals[1] = {junk[7:2], ret};
		vals[2] = {junk[1], cmax};
		vals[3] = {junk[0], tmax};
		vals[4] = thr;
		cfg_we <= 1'b1;
		for (int i = 0; i < 5; i++) begin
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(reg_idx_t'(i), vals[i]);
		end
		cfg_index <= RegSpare;
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random();
		op_t                op;
		logic [1:0]         w;
		logic signed [15:0] c;
		logic [16:0]        f;
		logic signed [15:0] tv;
		op = ($urandom_range(0, 7) == 0) ? OP_LOAD : OP_UPDATE;
		w  = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 4))
			0:       c = 16'($urandom);
			1:       c = '0;
			default: c = 16'(int'($urandom_range(0, 1200)) - 600);
		endcase
		case ($urandom_range(0, 7))
			0:       f = '0;
			1:       f = FracOne;
			2:       f = FracOne + 17'($urandom_range(1, 65535));
			3:       f = 17'($urandom_range(1, 255));
			default: f = 17'($urandom_range(1, 65535));
		endcase
		if ($urandom_range(0, 3) == 0)
			tv = 16'($urandom);
		else
			tv = 16'(int'($urandom_range(0, 1000)) - 500);
		send_word(op, w, c, f, tv);
	endtask

	task automatic run_directed();
		send_word(OP_LOAD,   2'd0, 16'sd0,      FracOne,    16'sd300);
		send_word(OP_UPDATE, 2'd0, 16'sd0,      FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd0, 16'sd0,      17'h1FFFF,  16'sd0);
		send_word(OP_UPDATE, 2'd0, 16'sd0,      17'd0,      -16'sd1);
		send_word(OP_UPDATE, 2'd0, 16'sd32767,  FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd0, 16'sd0,      FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd0, -16'sd100,   FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd1, -16'sd100,   17'd32768,  16'sd0);
		send_word(OP_UPDATE, 2'd1, -16'sd300,   FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd1, -16'sd32768, 17'd1,      16'sd0);
		send_word(OP_UPDATE, 2'd1, -16'sd1000,  FracOne,    16'sd0);
		send_word(OP_LOAD,   2'd3, 16'sd0,      17'd0,      -16'sd32768);
		send_word(OP_UPDATE, 2'd3, 16'sd0,      FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd3, 16'sd0,      17'h10001,  16'sd0);
		send_word(OP_LOAD,   2'd2, -16'sd1,     17'h1FFFF,  16'sd32767);
		send_word(OP_UPDATE, 2'd2, 16'sd0,      17'd1,      16'sd0);
		send_word(OP_UPDATE, 2'd2, 16'sd1,      FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd2, 16'sd0,      FracOne,    16'sd0);
		send_word(OP_UPDATE, 2'd3, -16'sd1,     17'hFFFF,   16'sd0);
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_pipe();

		for (int ph = 0; ph < PhaseCount; ph++) begin
			case (ph)
				0: program_regs('0, '0, '0, '0, '0);
				1: program_regs(8'hFF, 10'h3FF, 15'h7FFF, 15'h7FFF, 16'sh7FFF);
				2: program_regs(8'd16, 10'd300, 15'd500, 15'd1000, -16'sd32768);
				3: program_regs(8'($urandom), 10'($urandom), 15'($urandom_range(0, 2000)),
					15'($urandom_range(0, 4000)), 16'(int'($urandom_range(0, 4000)) - 2000));
				4: program_regs(8'($urandom), 10'($urandom), 15'($urandom), 15'($urandom),
					16'($urandom));
				default: program_regs(RstTargetDecay, RstReturnStep, RstContactLimit,
					RstTravelLimit, RstSoftThreshold);
			endcase
			calm = (ph == PhaseCount - 1);
			for (int n = 0; n < PhaseItems; n++) begin
				if (ph == 2 && n == 100)
					hold_req = 1'b1;
				if (ph == 3 && n == 120)
					drain_pipe();
				// gaps only in part of each phase but the calm last one, leaving runs at full rate
				if (!calm && (n % 96) < 60 && $urandom_range(0, 3) == 0)
					idle_input($urandom_range(1, 3));
				send_random();
			end
			drain_pipe();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("wheel_suspension_update_top verification clean");
		else
			$display("wheel_suspension_update_top verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/wsu_pkg.sv
rtl/wsu_calc.sv
rtl/wheel_suspension_update_top.sv
tb/tb.sv
